>>> src/rational_arith_reduce_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the rational arithmetic block.
// Shared clocked assertion forms, with and without a synchronous reset disable.
// ---------------------------------------------------------------------------
`ifndef RATIONAL_ARITH_REDUCE_ASSERT_SVH
`define RATIONAL_ARITH_REDUCE_ASSERT_SVH
// Assert an implication on every clock edge outside reset.
`define RAR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Assert a property that must also hold during reset.
`define RAR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

>>> src/rar_pkg.sv
// ---------------------------------------------------------------------------
// rar_pkg
// Shared constants, codes and command/status types of the rational block.
// ---------------------------------------------------------------------------
package rar_pkg;
  localparam int DataWidth = 32;
  localparam int OpWidth   = 3;
  localparam int StWidth   = 2;

  localparam logic [OpWidth-1:0] OP_ADD  = 3'd0;
  localparam logic [OpWidth-1:0] OP_SUB  = 3'd1;
  localparam logic [OpWidth-1:0] OP_MUL  = 3'd2;
  localparam logic [OpWidth-1:0] OP_DIV  = 3'd3;
  localparam logic [OpWidth-1:0] OP_NORM = 3'd4;
  // Spare codes behave as normalize of the first operand.
  localparam logic [OpWidth-1:0] OP_SPARE5 = 3'd5;
  localparam logic [OpWidth-1:0] OP_SPARE6 = 3'd6;
  localparam logic [OpWidth-1:0] OP_SPARE7 = 3'd7;

  localparam logic [StWidth-1:0] ST_OK       = 2'd0;
  localparam logic [StWidth-1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [StWidth-1:0] ST_OVERFLOW = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture operands
    logic mul1;     // first product pair
    logic mul2;     // second product pair
    logic combine;  // form n and d
    logic gcd_init; // start gcd
    logic gcd_step; // one gcd step
    logic div_init; // start division
    logic div_step; // one quotient bit
    logic finish;   // build result
  } rar_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic gcd_done;
    logic div_done;
  } rar_sts_t;
endpackage

>>> src/rar_if.sv
// ---------------------------------------------------------------------------
// rar_in_if / rar_out_if
// Valid/ready channels that carry operand and result items.
// ---------------------------------------------------------------------------
interface rar_in_if;
  logic                             valid;
  logic                             ready;
  logic [rar_pkg::OpWidth-1:0]      operation;
  logic signed [31:0]               a_num;
  logic signed [31:0]               a_den;
  logic signed [31:0]               b_num;
  logic signed [31:0]               b_den;
  modport source (output valid, operation, a_num, a_den, b_num, b_den, input ready);
  modport sink (input valid, operation, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rar_out_if;
  logic                        valid;
  logic                        ready;
  logic signed [31:0]          res_num;
  logic [30:0]                 res_den;
  logic [rar_pkg::StWidth-1:0] status;
  modport source (output valid, res_num, res_den, status, input ready);
  modport sink (input valid, res_num, res_den, status, output ready);
endinterface

>>> src/rar_datapath.sv
// ---------------------------------------------------------------------------
// rar_datapath
// Operand registers, a shared 32x32 multiplier, a binary gcd unit and a
// restoring divider that divides both parts by the gcd one bit per cycle.
// ---------------------------------------------------------------------------
module rar_datapath #(
  parameter int DATA_WIDTH = rar_pkg::DataWidth
) (
  input  logic                        clk,
  input  logic                        rst,
  input  rar_pkg::rar_cmd_t           cmd,
  output rar_pkg::rar_sts_t           sts,
  input  logic [rar_pkg::OpWidth-1:0] operation,
  input  logic [31:0]                 a_num,
  input  logic [31:0]                 a_den,
  input  logic [31:0]                 b_num,
  input  logic [31:0]                 b_den,
  output logic [31:0]                 res_num,
  output logic [30:0]                 res_den,
  output logic [rar_pkg::StWidth-1:0] status
);
  localparam int W  = DATA_WIDTH;
  localparam int PW = 2 * W + 1;      // sum of two products may carry
  localparam int CW = $clog2(PW + 1);
  localparam int SW = $clog2(PW);     // shift count width

  typedef struct packed {
    logic         neg;
    logic [W-1:0] mag;
  } smag_t;

  // Sign/magnitude of a raw operand, using only the low W bits.
  function automatic smag_t to_smag(input logic [31:0] raw);
    smag_t r;
    logic [W-1:0] v;
    v     = raw[W-1:0];
    r.neg = v[W-1];
    r.mag = v[W-1] ? (~v + 1'b1) : v;
    return r;
  endfunction

  logic [rar_pkg::OpWidth-1:0] op;
  smag_t an, ad, bn, bd;
  logic [2*W-1:0] p1, p2;
  logic p1n, p2n;
  logic [PW-1:0] nmag, dmag, u, v, qn, rem, dvd, gcd;
  logic nneg, dneg, zero_den;
  logic [SW-1:0] shift;
  logic [CW-1:0] cnt;
  logic dsel;   // 0 dividing numerator, 1 denominator
  logic done_g, done_d;

  // Multiplier operand selection for the product phases and the combine step.
  logic [W-1:0] mx, my;
  logic [2*W-1:0] prod;
  logic two;
  assign two = (op <= rar_pkg::OP_DIV);
  always_comb begin
    mx = an.mag;
    my = bd.mag;
    if (cmd.combine) begin
      mx = ad.mag;
      my = bd.mag;
    end else if (cmd.mul2) begin
      case (op)
        rar_pkg::OP_DIV: begin mx = ad.mag; my = bn.mag; end
        rar_pkg::OP_MUL: begin mx = ad.mag; my = bd.mag; end
        default:         begin mx = ad.mag; my = bn.mag; end
      endcase
    end else if (op == rar_pkg::OP_MUL) begin
      mx = an.mag;
      my = bn.mag;
    end
    prod = {{W{1'b0}}, mx} * {{W{1'b0}}, my};
  end

  // Zero-extended products and the sign of the second add/sub term.
  logic [PW-1:0] s1, s2;
  logic s2n;
  assign s1  = {1'b0, p1};
  assign s2  = {1'b0, p2};
  assign s2n = (op == rar_pkg::OP_SUB) ? ~p2n : p2n;

  // Division trial subtract.
  logic [PW:0] trial;
  logic        last_bit;
  assign trial    = {1'b0, rem[PW-2:0], dvd[PW-1]} - {1'b0, gcd};
  assign last_bit = (cnt == CW'(PW - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      done_g <= 1'b0;
      done_d <= 1'b0;
    end else begin
      if (cmd.load) begin
        op <= operation;
        an <= to_smag(a_num);
        ad <= to_smag(a_den);
        bn <= to_smag(b_num);
        bd <= to_smag(b_den);
      end
      // First product: an*bd (add/sub/div) or an*bn (mul).
      if (cmd.mul1) begin
        p1  <= prod;
        p1n <= (op == rar_pkg::OP_MUL) ? (an.neg ^ bn.neg) : (an.neg ^ bd.neg);
      end
      // Second product: ad*bn (add/sub/div) or ad*bd (mul).
      if (cmd.mul2) begin
        p2  <= prod;
        p2n <= (op == rar_pkg::OP_MUL) ? (ad.neg ^ bd.neg) : (ad.neg ^ bn.neg);
      end
      // Form n and d; d for add/sub is ad*bd from the multiplier in this step.
      if (cmd.combine) begin
        case (op)
          rar_pkg::OP_ADD, rar_pkg::OP_SUB: begin
            if (p1n == s2n) begin
              nmag <= s1 + s2;
              nneg <= p1n;
            end else if (s1 >= s2) begin
              nmag <= s1 - s2;
              nneg <= p1n;
            end else begin
              nmag <= s2 - s1;
              nneg <= s2n;
            end
            dmag <= {1'b0, prod};
            dneg <= ad.neg ^ bd.neg;
          end
          rar_pkg::OP_MUL, rar_pkg::OP_DIV: begin
            nmag <= s1;
            nneg <= p1n;
            dmag <= s2;
            dneg <= p2n;
          end
          default: begin
            nmag <= {{(PW-W){1'b0}}, an.mag};
            nneg <= an.neg;
            dmag <= {{(PW-W){1'b0}}, ad.mag};
            dneg <= ad.neg;
          end
        endcase
        zero_den <= (ad.mag == '0) || (two && bd.mag == '0);
      end
      // Binary gcd: strip common twos, then subtract.
      if (cmd.gcd_init) begin
        u      <= nmag;
        v      <= dmag;
        shift  <= '0;
        done_g <= (nmag == '0) || (dmag == '0);
      end
      if (cmd.gcd_step && !done_g) begin
        if (!u[0] && !v[0]) begin
          u     <= u >> 1;
          v     <= v >> 1;
          shift <= shift + 1'b1;
        end else if (!u[0]) begin
          u <= u >> 1;
        end else if (!v[0]) begin
          v <= v >> 1;
        end else if (u >= v) begin
          u <= u - v;
          if (u == v) begin
            done_g <= 1'b1;
          end
        end else begin
          v <= v - u;
        end
      end
      // Restoring division of numerator, then denominator, by the gcd.
      if (cmd.div_init) begin
        gcd    <= v << shift;
        dvd    <= nmag;
        rem    <= '0;
        qn     <= '0;
        cnt    <= '0;
        dsel   <= 1'b0;
        done_d <= 1'b0;
      end
      if (cmd.div_step && !done_d) begin
        qn <= {qn[PW-2:0], !trial[PW]};
        // The numerator quotient is parked in u and the denominator loaded.
        if (last_bit && !dsel) begin
          dvd <= dmag;
          rem <= '0;
        end else begin
          dvd <= dvd << 1;
          rem <= trial[PW] ? {rem[PW-2:0], dvd[PW-1]} : trial[PW-1:0];
        end
        if (last_bit) begin
          cnt <= '0;
          if (dsel) begin
            done_d <= 1'b1;
          end else begin
            dsel <= 1'b1;
            u    <= {qn[PW-2:0], !trial[PW]};
          end
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
      // Range check and result build.
      if (cmd.finish) begin
        if (zero_den || dmag == '0) begin
          res_num <= '0; res_den <= '0; status <= rar_pkg::ST_ZERO_DEN;
        end else if (nmag == '0) begin
          res_num <= '0; res_den <= 31'd1; status <= rar_pkg::ST_OK;
        end else if (qn > PW'((64'd1 << (W-1)) - 64'd1) ||
                     u > ((nneg ^ dneg) ? PW'(64'd1 << (W-1))
                                        : PW'((64'd1 << (W-1)) - 64'd1))) begin
          res_num <= '0; res_den <= '0; status <= rar_pkg::ST_OVERFLOW;
        end else begin
          res_num <= (nneg ^ dneg) ? 32'(-u) : 32'(u);
          res_den <= 31'(qn);
          status  <= rar_pkg::ST_OK;
        end
      end
    end
  end

  assign sts.gcd_done = done_g;
  assign sts.div_done = done_d;
endmodule

>>> src/rar_ctrl.sv
// ---------------------------------------------------------------------------
// rar_ctrl
// Sequencer: accept, two products, combine, gcd loop, division, result.
// ---------------------------------------------------------------------------
`include "rational_arith_reduce_assert.svh"
module rar_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output rar_pkg::rar_cmd_t cmd,
  input  rar_pkg::rar_sts_t sts
);
  typedef enum logic [2:0] {
    S_IDLE, S_MUL1, S_MUL2, S_COMB, S_GCD, S_DIV, S_FIN, S_OUT
  } state_t;
  state_t state;
  logic gcd_started;

  assign in_ready = (state == S_IDLE);

  // Commands decode from the state; the first gcd cycle loads the gcd unit.
  always_comb begin
    cmd          = '0;
    cmd.load     = (state == S_IDLE) && in_valid;
    cmd.mul1     = (state == S_MUL1);
    cmd.mul2     = (state == S_MUL2);
    cmd.combine  = (state == S_COMB);
    cmd.gcd_init = (state == S_GCD) && !gcd_started;
    cmd.gcd_step = (state == S_GCD) && gcd_started;
    cmd.div_init = (state == S_GCD) && gcd_started && sts.gcd_done;
    cmd.div_step = (state == S_DIV);
    cmd.finish   = (state == S_FIN);
  end

  // State register and registered output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      gcd_started <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) state <= S_MUL1;
        S_MUL1: state <= S_MUL2;
        S_MUL2: state <= S_COMB;
        S_COMB: begin
          state       <= S_GCD;
          gcd_started <= 1'b0;
        end
        S_GCD: begin
          gcd_started <= 1'b1;
          if (gcd_started && sts.gcd_done) state <= S_DIV;
        end
        S_DIV: if (sts.div_done) state <= S_FIN;
        S_FIN: begin
          state     <= S_OUT;
          out_valid <= 1'b1;
        end
        S_OUT: if (out_ready) begin
          out_valid <= 1'b0;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `RAR_ASSERT(a_valid_in_out, out_valid == (state == S_OUT), "out_valid out of step with state")
  `RAR_ASSERT(a_no_accept_busy, (state != S_IDLE) |-> !in_ready, "input taken while busy")
  `RAR_ASSERT(a_fin_to_out, (state == S_FIN) |=> out_valid, "result not presented")
  `RAR_ASSERT_ALWAYS(a_rst_idle, rst |=> (state == S_IDLE && !out_valid), "reset not idle")
endmodule

>>> src/rational_arith_reduce.sv
// Throughput: one item at a time; the next is taken the cycle after the
// result transfer.
// Reset: synchronous, active high; returns to idle and drops out.valid.
// ---------------------------------------------------------------------------
// rational_arith_reduce
// Signed fraction add/sub/mul/div/normalize with gcd reduction.
// ---------------------------------------------------------------------------
module rational_arith_reduce #(
  parameter int DATA_WIDTH = rar_pkg::DataWidth
) (
  input  logic     clk,
  input  logic     rst,
  rar_in_if.sink   in,
  rar_out_if.source out
);
  rar_pkg::rar_cmd_t cmd;
  rar_pkg::rar_sts_t sts;

  rar_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in.valid), .in_ready(in.ready),
    .out_valid(out.valid), .out_ready(out.ready),
    .cmd(cmd), .sts(sts)
  );

  rar_datapath #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .operation(in.operation), .a_num(in.a_num), .a_den(in.a_den),
    .b_num(in.b_num), .b_den(in.b_den),
    .res_num(out.res_num), .res_den(out.res_den), .status(out.status)
  );
endmodule

>>> sim/rational_arith_reduce_tb.sv
// ---------------------------------------------------------------------------
// rational_arith_reduce_tb
// Drives signed fraction operations into the rational block and checks each
// reduced result against a behavioral predictor, under several idle patterns.
// ---------------------------------------------------------------------------
module rational_arith_reduce_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 20000;
  localparam int DrainCycles   = 500;

  typedef struct packed {
    logic signed [31:0] num;
    logic [30:0]        den;
    logic [1:0]         status;
  } fraction_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rar_in_if  op_ch ();
  rar_out_if res_ch ();

  rational_arith_reduce u_top (
    .clk (clk),
    .rst (rst),
    .in  (op_ch.sink),
    .out (res_ch.source)
  );

  always #2 clk = ~clk;

  fraction_res_t reduced_q[$];
  int  send_idle_pct  = 0;
  int  stall_pct      = 0;
  int  error_count    = 0;
  int  result_count   = 0;
  int  sent_count     = 0;
  int  quiet_cycles   = 0;
  int  op_seen[8];

  // Exact rational arithmetic followed by reduction to lowest terms.
  function automatic fraction_res_t reduce_fraction(logic [2:0] opc,
      logic signed [31:0] an, ad, bn, bd);
    fraction_res_t r;
    logic signed [65:0] n, d, t, p1, p2;
    logic [65:0] nm, dm, x, y;
    logic two;
    two = (opc <= rar_pkg::OP_DIV);
    r = '0;
    if (ad == 0 || (two && bd == 0)) begin
      r.status = rar_pkg::ST_ZERO_DEN;
      return r;
    end
    p1 = 66'(an) * 66'(bd);
    p2 = 66'(ad) * 66'(bn);
    case (opc)
      rar_pkg::OP_ADD: begin n = p1 + p2; d = 66'(ad) * 66'(bd); end
      rar_pkg::OP_SUB: begin n = p1 - p2; d = 66'(ad) * 66'(bd); end
      rar_pkg::OP_MUL: begin n = 66'(an) * 66'(bn); d = 66'(ad) * 66'(bd); end
      rar_pkg::OP_DIV: begin n = p1; d = p2; end
      default: begin n = 66'(an); d = 66'(ad); end
    endcase
    if (d == 0) begin
      r.status = rar_pkg::ST_ZERO_DEN;
      return r;
    end
    if (n == 0) begin
      r.den = 31'd1;
      r.status = rar_pkg::ST_OK;
      return r;
    end
    if (d < 0) begin n = -n; d = -d; end
    nm = n < 0 ? 66'(-n) : 66'(n);
    dm = 66'(d);
    x = nm;
    y = dm;
    while (y != 0) begin
      t = 66'(x % y);
      x = y;
      y = 66'(t);
    end
    nm = nm / x;
    dm = dm / x;
    if (dm > 66'h7FFF_FFFF || nm > (n < 0 ? 66'h8000_0000 : 66'h7FFF_FFFF)) begin
      r.status = rar_pkg::ST_OVERFLOW;
      return r;
    end
    r.num = n < 0 ? -32'(nm) : 32'(nm);
    r.den = 31'(dm);
    r.status = rar_pkg::ST_OK;
    return r;
  endfunction

  // Send one operation and record its predicted result at the transfer.
  // Valid stays high between items unless the sender idles.
  task automatic send_op(logic [2:0] opc, logic signed [31:0] an, ad, bn, bd);
    while ($urandom_range(99) < send_idle_pct) begin
      op_ch.valid <= 1'b0;
      @(posedge clk);
    end
    op_ch.valid     <= 1'b1;
    op_ch.operation <= opc;
    op_ch.a_num     <= an;
    op_ch.a_den     <= ad;
    op_ch.b_num     <= bn;
    op_ch.b_den     <= bd;
    @(posedge clk);
    while (!op_ch.ready) @(posedge clk);
    reduced_q.push_back(reduce_fraction(opc, an, ad, bn, bd));
    op_seen[opc]++;
    sent_count++;
  endtask

  // Receiver readiness, with random stalls.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare each result transfer with the oldest prediction.
  always @(posedge clk) begin
    fraction_res_t exp_r;
    if (!rst && res_ch.valid && res_ch.ready) begin
      result_count++;
      if (reduced_q.size() == 0) begin
        $display("%0t: unexpected result %0d/%0d status %0d", $time,
                 res_ch.res_num, res_ch.res_den, res_ch.status);
        error_count++;
      end else begin
        exp_r = reduced_q.pop_front();
        if (res_ch.res_num !== exp_r.num || res_ch.res_den !== exp_r.den ||
            res_ch.status !== exp_r.status) begin
          $display("%0t: expected %0d/%0d status %0d, actual %0d/%0d status %0d",
                   $time, exp_r.num, exp_r.den, exp_r.status, res_ch.res_num,
                   res_ch.res_den, res_ch.status);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on either side.
  always @(posedge clk) begin
    if ((op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (!rst) begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog expired with %0d results outstanding", reduced_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Random operand with a bias toward small values and edge values.
  function automatic logic signed [31:0] rand_operand();
    case ($urandom_range(9))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return 0;
      3, 4: return $urandom;
      5: return 32'($urandom_range(1 << 16)) * ($urandom_range(1) ? 1 : -1);
      default: return $signed(32'($urandom_range(60))) - 30;
    endcase
  endfunction

  task automatic test_directed();
    send_op(rar_pkg::OP_ADD, 1, 2, 1, 3);
    send_op(rar_pkg::OP_SUB, 1, 2, 1, 2);
    send_op(rar_pkg::OP_MUL, -2, 4, 3, -9);
    send_op(rar_pkg::OP_DIV, 3, 4, -6, 8);
    send_op(rar_pkg::OP_NORM, 12, -18, 5, 7);
    send_op(rar_pkg::OP_SPARE5, 0, -7, 0, 0);
    send_op(rar_pkg::OP_SPARE6, 32'sh8000_0000, -1, 0, 0);
    send_op(rar_pkg::OP_SPARE7, 32'sh8000_0000, 1, 0, 0);
    send_op(rar_pkg::OP_ADD, 1, 0, 1, 1);
    send_op(rar_pkg::OP_MUL, 1, 1, 1, 0);
    send_op(rar_pkg::OP_NORM, 5, 0, 1, 1);
    send_op(rar_pkg::OP_NORM, 5, 1, 0, 0);
    send_op(rar_pkg::OP_DIV, 1, 2, 0, 5);
    send_op(rar_pkg::OP_ADD, 32'sh7FFF_FFFF, 1, 32'sh7FFF_FFFF, 1);
    send_op(rar_pkg::OP_MUL, 32'sh8000_0000, 1, 32'sh8000_0000, 1);
    send_op(rar_pkg::OP_MUL, 32'sh8000_0000, 1, -1, 1);
    send_op(rar_pkg::OP_DIV, 1, 32'sh7FFF_FFFF, 1, 32'sh7FFF_FFFF);
    send_op(rar_pkg::OP_SUB, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
            32'sh8000_0000);
    send_op(rar_pkg::OP_DIV, 32'sh7FFF_FFFF, 32'sh8000_0000, -1, -1);
    send_op(rar_pkg::OP_ADD, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF,
            32'shFFFF_FFFF);
    send_op(rar_pkg::OP_SUB, 0, 32'sh8000_0000, 0, 3);
  endtask

  task automatic test_random(int count, int idle_pct, int stall);
    send_idle_pct = idle_pct;
    stall_pct = stall;
    repeat (count) begin
      send_op(3'($urandom_range(7)), rand_operand(), rand_operand(),
              rand_operand(), rand_operand());
    end
  endtask

  task automatic wait_drained();
    op_ch.valid <= 1'b0;
    while (reduced_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  initial begin
    op_ch.valid     <= 1'b0;
    op_ch.operation <= '0;
    op_ch.a_num     <= '0;
    op_ch.a_den     <= '0;
    op_ch.b_num     <= '0;
    op_ch.b_den     <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(300, 0, 0);
    test_random(300, 68, 0);
    test_random(300, 0, 68);
    test_random(300, 38, 38);
    stall_pct = 0;
    wait_drained();
    $display("sent %0d operations (add %0d sub %0d mul %0d div %0d), %0d results",
             sent_count, op_seen[0], op_seen[1], op_seen[2], op_seen[3], result_count);
    $display("normalize and spare codes %0d, under four idle patterns",
             op_seen[4] + op_seen[5] + op_seen[6] + op_seen[7]);
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
